// ===== hdl/rotary_embedding_cos_sin_gen_unit_defines.svh =====
// Assertion macros shared by the rotary embedding cos/sin generator modules
`ifndef ROTARY_EMBEDDING_COS_SIN_GEN_UNIT_DEFINES_SVH
`define ROTARY_EMBEDDING_COS_SIN_GEN_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSG_ASSERT(lbl, prop, msg)
`define RSG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/rsg_pkg.sv =====
// Package with constants, types and the frequency ROM of the rotary cos/sin generator
`default_nettype none
package rsg_pkg;

    localparam int ROPE_DIM     = 32;
    localparam int ROPE_BASE    = 10000;
    localparam int CORDIC_STEPS = 16;

    localparam int HALF_DIM  = (ROPE_DIM / 2 > 32) ? 32 : ROPE_DIM / 2;
    localparam int FIDX_W    = (HALF_DIM > 1) ? $clog2(HALF_DIM) : 1;
    localparam int ROM_DEPTH = 1 << FIDX_W;
    localparam int CNT_W     = 6;
    localparam int POS_W     = 16;
    localparam int ROM_W     = 40;
    localparam int PHASE_W   = 32;
    localparam int DATA_W    = 34;
    localparam int OUT_W     = 16;
    localparam int STEP_W    = 5;
    localparam int NUM_CELLS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

    localparam logic [63:0] ONE_Q60        = 64'd1 << 60;
    localparam logic [63:0] INV_TWO_PI_Q60 = 64'd183493156455125077;
    localparam logic [63:0] ROPE_BASE_EFF  = (ROPE_BASE < 1) ? 64'd1 : 64'(ROPE_BASE);
    localparam logic [63:0] LIMIT_Q60      = ONE_Q60 / ROPE_BASE_EFF;

    localparam logic signed [DATA_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [CNT_W-1:0] LAST_DUP = CNT_W'(2 * HALF_DIM - 1);
    localparam logic [CNT_W-1:0] LAST_ONE = CNT_W'(HALF_DIM - 1);

    typedef logic [ROM_W-1:0] rom_t [0:ROM_DEPTH-1];

    typedef struct packed {
        logic [CNT_W-1:0] element_index;
        logic             last;
        logic             flip;
    } tag_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        tag_t                     tag;
    } cell_t;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] pw;
        logic [63:0] inv;
        logic [63:0] t;
        lo  = 64'd0;
        hi  = ONE_Q60;
        inv = ONE_Q60;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            rom[i] = '0;
        end
        for (int it = 0; it < 64; it++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                pw  = ONE_Q60;
                for (int k = 0; k < HALF_DIM; k++)
                begin
                    pw = mul_q60(pw, mid);
                end
                if (pw <= LIMIT_Q60)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 64'd1;
                end
            end
        end
        for (int i = 0; i < HALF_DIM; i++)
        begin
            if (i > 0)
            begin
                inv = mul_q60(inv, lo);
            end
            t      = mul_q60(inv, INV_TWO_PI_Q60) + (64'd1 << 19);
            rom[i] = t[59:20];
        end
        return rom;
    endfunction

    localparam rom_t FREQ_ROM = build_rom();

    function automatic logic [PHASE_W-1:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [PHASE_W-1:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rsg_seq.sv =====
// Sequencer: walks frequency indices, ROM lookup, phase multiply and quadrant fold
`default_nettype none
`include "rotary_embedding_cos_sin_gen_unit_defines.svh"
module rsg_seq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic                           layout_mode,
    input  wire logic                           pos_valid,
    output      logic                           pos_stall,
    input  wire logic [rsg_pkg::POS_W-1:0]      position,
    input  wire logic                           advance,
    output      logic                           head_valid,
    output      rsg_pkg::cell_t                 head_data
);

    logic                          mode_reg;
    logic                          busy_reg,  busy_next;
    logic [rsg_pkg::POS_W-1:0]     pos_reg,   pos_next;
    logic [rsg_pkg::CNT_W-1:0]     cnt_reg,   cnt_next;
    logic [rsg_pkg::CNT_W-1:0]     last_cnt;
    logic                          at_last;
    logic                          accept;
    logic [rsg_pkg::CNT_W-1:0]     fidx_full;

    logic                          a_valid_reg;
    logic [rsg_pkg::ROM_W-1:0]     a_rom_reg;
    logic [rsg_pkg::POS_W-1:0]     a_pos_reg;
    rsg_pkg::tag_t                 a_tag_reg;

    logic                          b_valid_reg;
    rsg_pkg::cell_t                b_data_reg, b_data_next;

    logic [rsg_pkg::POS_W+rsg_pkg::ROM_W-1:0] prod;
    logic [rsg_pkg::PHASE_W-1:0]              phase;
    logic [rsg_pkg::PHASE_W-1:0]              folded;
    logic                                     flip;

    assign cfg_ready = 1'b1;
    assign last_cnt  = mode_reg ? rsg_pkg::LAST_ONE : rsg_pkg::LAST_DUP;
    assign at_last   = (cnt_reg == last_cnt);
    assign pos_stall = busy_reg && !(advance && at_last);
    assign accept    = pos_valid && !pos_stall;
    assign fidx_full = mode_reg ? cnt_reg : (cnt_reg >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= layout_mode;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        if (busy_reg && advance)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            pos_next  = position;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= busy_reg;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_rom_reg               <= rsg_pkg::FREQ_ROM[fidx_full[rsg_pkg::FIDX_W-1:0]];
            a_pos_reg               <= pos_reg;
            a_tag_reg.element_index <= cnt_reg;
            a_tag_reg.last          <= at_last;
            a_tag_reg.flip          <= 1'b0;
            b_data_reg              <= b_data_next;
        end
    end

    // fold phases in [1/4, 3/4) turn by half a turn
    always_comb
    begin
        prod   = (rsg_pkg::POS_W + rsg_pkg::ROM_W)'(a_pos_reg)
               * (rsg_pkg::POS_W + rsg_pkg::ROM_W)'(a_rom_reg);
        phase  = prod[rsg_pkg::ROM_W-1:rsg_pkg::ROM_W-rsg_pkg::PHASE_W];
        flip   = phase[rsg_pkg::PHASE_W-1] ^ phase[rsg_pkg::PHASE_W-2];
        folded = {phase[rsg_pkg::PHASE_W-1] ^ flip, phase[rsg_pkg::PHASE_W-2:0]};
        b_data_next.x        = rsg_pkg::CORDIC_GAIN_Q30;
        b_data_next.y        = '0;
        b_data_next.z        = {{(rsg_pkg::DATA_W-rsg_pkg::PHASE_W){folded[rsg_pkg::PHASE_W-1]}},
                                folded};
        b_data_next.tag      = a_tag_reg;
        b_data_next.tag.flip = flip;
    end

    assign head_valid = b_valid_reg;
    assign head_data  = b_data_reg;

    `RSG_ASSERT(a_cnt_in_range, !busy_reg || (cnt_reg <= last_cnt), "index counter past last")
    `RSG_ASSERT_NEXT(a_accept_starts, accept, busy_reg && (cnt_reg == '0),
        "accepted position did not start at index zero")
    `RSG_ASSERT_NEXT(a_freeze_holds, !advance, $stable(a_valid_reg) && $stable(b_valid_reg),
        "front stages moved while frozen")

endmodule
`default_nettype wire

// ===== hdl/rsg_cordic_cell.sv =====
// One CORDIC rotation cell of the chain
`default_nettype none
module rsg_cordic_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic [rsg_pkg::STEP_W-1:0]  step,
    input  wire logic                        src_valid,
    input  wire rsg_pkg::cell_t              src_data,
    output      logic                        dst_valid,
    output      rsg_pkg::cell_t              dst_data
);

    logic                               valid_reg;
    rsg_pkg::cell_t                     data_reg, data_next;
    logic signed [rsg_pkg::DATA_W-1:0]  x;
    logic signed [rsg_pkg::DATA_W-1:0]  y;
    logic signed [rsg_pkg::DATA_W-1:0]  z;
    logic signed [rsg_pkg::DATA_W-1:0]  dx;
    logic signed [rsg_pkg::DATA_W-1:0]  dy;
    logic signed [rsg_pkg::DATA_W-1:0]  at;

    always_comb
    begin
        x  = src_data.x;
        y  = src_data.y;
        z  = src_data.z;
        dx = y >>> step;
        dy = x >>> step;
        at = $signed({{(rsg_pkg::DATA_W-rsg_pkg::PHASE_W){1'b0}}, rsg_pkg::atan_turn(step)});
        data_next.tag = src_data.tag;
        if (!z[rsg_pkg::DATA_W-1])
        begin
            data_next.x = x - dx;
            data_next.y = y + dy;
            data_next.z = z - at;
        end
        else
        begin
            data_next.x = x + dx;
            data_next.y = y - dy;
            data_next.z = z + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_data  = data_reg;

endmodule
`default_nettype wire

// ===== hdl/rotary_embedding_cos_sin_gen_unit.sv =====
// Usage:
//   Position channel: pos_valid / pos_stall / position. A transaction completes at an edge
//   with pos_valid high and pos_stall low; each position yields a burst of results.
//   Result channel: res_valid / res_stall with element_index, cos_value, sin_value, last.
//   last marks the final result of a position's burst.
//   Configuration: cfg_valid / cfg_ready / layout_mode, cfg_ready is always high; write
//   only while no burst is in flight. Mode 0 gives 2*HALF_DIM results per position
//   (32 here), mode 1 gives HALF_DIM (16 here).
//   The first result of a position passes the sequencer, ROM, multiply and fold stages,
//   one cell per CORDIC step and the output register.
//   Throughput: one result per cycle while the output is not stalled; a new position is
//   taken at the edge on which the previous one issues its last index, so back-to-back
//   positions run with no gap between their bursts.
//   A stalled result holds in the output register and the whole chain freezes with it.
//   Reset clears all valid bits and sets layout_mode to 0.
`default_nettype none
`include "rotary_embedding_cos_sin_gen_unit_defines.svh"
module rotary_embedding_cos_sin_gen_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic                               layout_mode,
    input  wire logic                               pos_valid,
    output      logic                               pos_stall,
    input  wire logic [rsg_pkg::POS_W-1:0]          position,
    output      logic                               res_valid,
    input  wire logic                               res_stall,
    output      logic [rsg_pkg::CNT_W-1:0]          element_index,
    output      logic signed [rsg_pkg::OUT_W-1:0]   cos_value,
    output      logic signed [rsg_pkg::OUT_W-1:0]   sin_value,
    output      logic                               last
);

    localparam int N = rsg_pkg::NUM_CELLS;

    logic                              advance;
    logic [N:0]                        chain_valid;
    rsg_pkg::cell_t                    chain_data [0:N];

    logic                              res_valid_reg;
    logic [rsg_pkg::CNT_W-1:0]         index_reg,  index_next;
    logic signed [rsg_pkg::OUT_W-1:0]  cos_reg,    cos_next;
    logic signed [rsg_pkg::OUT_W-1:0]  sin_reg,    sin_next;
    logic                              last_reg,   last_next;

    assign advance = !res_valid_reg || !res_stall;

    rsg_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .layout_mode (layout_mode),
        .pos_valid   (pos_valid),
        .pos_stall   (pos_stall),
        .position    (position),
        .advance     (advance),
        .head_valid  (chain_valid[0]),
        .head_data   (chain_data[0])
    );

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        rsg_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .step      (rsg_pkg::STEP_W'(k)),
            .src_valid (chain_valid[k]),
            .src_data  (chain_data[k]),
            .dst_valid (chain_valid[k+1]),
            .dst_data  (chain_data[k+1])
        );
    end

    function automatic logic signed [rsg_pkg::OUT_W-1:0] to_q15(
        input logic signed [rsg_pkg::DATA_W-1:0] v
    );
        logic signed [rsg_pkg::DATA_W-1:0] r;
        r = (v + $signed(rsg_pkg::DATA_W'(1 << 14))) >>> 15;
        if (r > $signed(rsg_pkg::DATA_W'(32767)))
        begin
            return 16'sh7FFF;
        end
        if (r < -$signed(rsg_pkg::DATA_W'(32768)))
        begin
            return 16'sh8000;
        end
        return r[rsg_pkg::OUT_W-1:0];
    endfunction

    always_comb
    begin
        index_next = chain_data[N].tag.element_index;
        last_next  = chain_data[N].tag.last;
        if (chain_data[N].tag.flip)
        begin
            cos_next = to_q15(-chain_data[N].x);
            sin_next = to_q15(-chain_data[N].y);
        end
        else
        begin
            cos_next = to_q15(chain_data[N].x);
            sin_next = to_q15(chain_data[N].y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= chain_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg <= index_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
            last_reg  <= last_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign element_index = index_reg;
    assign cos_value     = cos_reg;
    assign sin_value     = sin_reg;
    assign last          = last_reg;

    `RSG_ASSERT(a_rise_from_chain, !$rose(res_valid) || $past(chain_valid[N]),
        "result appeared without a chain transaction")
    `RSG_ASSERT_NEXT(a_tail_frozen, res_valid && res_stall, $stable(chain_valid[N]),
        "chain tail moved during output stall")

endmodule
`default_nettype wire

// ===== bench/tb_rotary_embedding_cos_sin_gen_unit.sv =====
// Self-checking testbench for the rotary embedding cos/sin generator with its own fixed-point predictor
`default_nettype none
module tb_rotary_embedding_cos_sin_gen_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF = (rsg_pkg::ROPE_DIM / 2 > 32) ? 32 : rsg_pkg::ROPE_DIM / 2;
    localparam int STEPS = (rsg_pkg::CORDIC_STEPS > 24) ? 24 :
                           ((rsg_pkg::CORDIC_STEPS < 0) ? 0 : rsg_pkg::CORDIC_STEPS);
    localparam logic [63:0] BASE_EFF = (rsg_pkg::ROPE_BASE < 1) ? 64'd1 : 64'(rsg_pkg::ROPE_BASE);
    localparam logic [63:0] Q60_ONE = 64'd1 << 60;
    localparam logic [63:0] TURN_PER_RAD_Q60 = 64'd183493156455125077;
    localparam longint GAIN_Q30 = 652032874;
    localparam int SETTLE = 3 + rsg_pkg::CORDIC_STEPS + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX = 10;

    typedef enum logic {
        LAYOUT_PAIRED = 1'b0,
        LAYOUT_SPLIT  = 1'b1
    } layout_e;

    typedef struct packed {
        logic [rsg_pkg::CNT_W-1:0] element_index;
        logic [rsg_pkg::OUT_W-1:0] cos_value;
        logic [rsg_pkg::OUT_W-1:0] sin_value;
        logic                      last;
    } rope_pair_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic                              layout_mode = 1'b0;
    logic                              pos_valid = 1'b0;
    logic                              pos_stall;
    logic [rsg_pkg::POS_W-1:0]         position = '0;
    logic                              res_valid;
    logic                              res_stall = 1'b0;
    logic [rsg_pkg::CNT_W-1:0]         element_index;
    logic signed [rsg_pkg::OUT_W-1:0]  cos_value;
    logic signed [rsg_pkg::OUT_W-1:0]  sin_value;
    logic                              last;

    logic [rsg_pkg::POS_W-1:0] pending_positions [$];
    rope_pair_t                expected_pairs [$];
    logic [39:0]               freq_turn_rom [0:31];
    logic [31:0]               atan_turn_tbl [0:23];
    layout_e                   model_layout = LAYOUT_PAIRED;
    logic                      pos_taken = 1'b0;
    logic                      cfg_taken = 1'b0;
    logic                      steady = 1'b0;
    int                        cycle_count = 0;
    int                        fail_count = 0;
    int                        positions_sent = 0;
    int                        results_checked = 0;
    int                        layout_writes = 0;

    rotary_embedding_cos_sin_gen_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .layout_mode   (layout_mode),
        .pos_valid     (pos_valid),
        .pos_stall     (pos_stall),
        .position      (position),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .element_index (element_index),
        .cos_value     (cos_value),
        .sin_value     (sin_value),
        .last          (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return wide[123:60];
    endfunction

    function automatic logic [rsg_pkg::OUT_W-1:0] round_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[rsg_pkg::OUT_W-1:0];
    endfunction

    function automatic void predict_rope_pairs(input logic [rsg_pkg::POS_W-1:0] pos,
                                               input layout_e mode);
        int          reps;
        int          total;
        int          n;
        logic [55:0] prod;
        logic [31:0] phase;
        logic [31:0] shifted;
        logic [31:0] folded;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        rope_pair_t  pair;
        reps  = (mode == LAYOUT_SPLIT) ? 1 : 2;
        total = HALF * reps;
        n     = 0;
        for (int i = 0; i < HALF; i++)
        begin
            prod    = 56'(pos) * 56'(freq_turn_rom[i]);
            phase   = prod[39:8];
            shifted = phase + 32'h4000_0000;
            flip    = shifted[31];
            folded  = flip ? (phase ^ 32'h8000_0000) : phase;
            z       = longint'($signed(folded));
            x       = GAIN_Q30;
            y       = 0;
            for (int k = 0; k < STEPS; k++)
            begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(atan_turn_tbl[k]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(atan_turn_tbl[k]);
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            for (int r = 0; r < reps; r++)
            begin
                pair.element_index = rsg_pkg::CNT_W'(i * reps + r);
                pair.cos_value     = round_q15(x);
                pair.sin_value     = round_q15(y);
                pair.last          = (n == total - 1);
                expected_pairs.push_back(pair);
                n++;
            end
        end
    endfunction

    initial
    begin : freq_table
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] pw;
        logic [63:0] inv;
        logic [63:0] limit;
        logic [63:0] rounded;
        atan_turn_tbl = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                          32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                          32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                          32'd166886, 32'd83443, 32'd41722, 32'd20861,
                          32'd10430, 32'd5215, 32'd2608, 32'd1304,
                          32'd652, 32'd326, 32'd163, 32'd81};
        limit = Q60_ONE / BASE_EFF;
        lo    = 64'd0;
        hi    = Q60_ONE;
        inv   = Q60_ONE;
        for (int i = 0; i < 32; i++)
        begin
            freq_turn_rom[i] = '0;
        end
        if (HALF > 0)
        begin
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 64'd1) / 64'd2;
                pw  = Q60_ONE;
                for (int k = 0; k < HALF; k++)
                begin
                    pw = q60_mul(pw, mid);
                end
                if (pw <= limit)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 64'd1;
                end
            end
            for (int i = 0; i < HALF; i++)
            begin
                if (i > 0)
                begin
                    inv = q60_mul(inv, lo);
                end
                rounded          = q60_mul(inv, TURN_PER_RAD_Q60) + (64'd1 << 19);
                freq_turn_rom[i] = rounded[59:20];
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pos_valid <= 1'b0;
        end
        else if (!pos_valid || pos_taken)
        begin
            if (pending_positions.size() != 0 && (steady || $urandom_range(0, 99) >= 22))
            begin
                pos_valid <= 1'b1;
                position  <= pending_positions.pop_front();
            end
            else
            begin
                pos_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        res_stall <= rst_n && !steady && ($urandom_range(0, 99) < 22);
    end

    always @(posedge clk)
    begin : monitor
        rope_pair_t want;
        pos_taken <= pos_valid && !pos_stall;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                model_layout = layout_e'(layout_mode);
                layout_writes++;
            end
            if (pos_valid && !pos_stall)
            begin
                predict_rope_pairs(position, model_layout);
                positions_sent++;
            end
            if (res_valid && !res_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                    begin
                        $display("unexpected result: idx %0d cos %0d sin %0d last %0b",
                                 element_index, cos_value, sin_value, last);
                    end
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    results_checked++;
                    if (element_index !== want.element_index ||
                        cos_value !== $signed(want.cos_value) ||
                        sin_value !== $signed(want.sin_value) || last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("result %0d wrong: expected idx %0d cos %0d sin %0d last %0b",
                                     results_checked, want.element_index,
                                     $signed(want.cos_value), $signed(want.sin_value), want.last);
                            $display("    actual idx %0d cos %0d sin %0d last %0b",
                                     element_index, cos_value, sin_value, last);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pairs.size());
            $display("rotary_embedding_cos_sin_gen_unit: mismatch");
            $finish;
        end
    end

    task automatic write_layout(input layout_e mode);
        @(negedge clk);
        cfg_valid   <= 1'b1;
        layout_mode <= mode;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_positions.size() != 0 || pos_valid || expected_pairs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [rsg_pkg::POS_W-1:0] corner_positions [$];
        logic [rsg_pkg::POS_W-1:0] pick;
        corner_positions = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0064, 16'h03E8,
                             16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_layout(LAYOUT_PAIRED);
        foreach (corner_positions[i])
        begin
            pending_positions.push_back(corner_positions[i]);
        end
        wait_idle();

        write_layout(LAYOUT_SPLIT);
        foreach (corner_positions[i])
        begin
            pending_positions.push_back(corner_positions[i]);
        end
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_layout((ph % 2 == 0) ? LAYOUT_PAIRED : LAYOUT_SPLIT);
            steady = (ph == 2);
            repeat (19)
            begin
                case ($urandom_range(0, 3))
                    0:       pick = 16'($urandom_range(0, 63));
                    1:       pick = 16'($urandom_range(65000, 65535));
                    default: pick = 16'($urandom);
                endcase
                pending_positions.push_back(pick);
            end
            wait_idle();
        end
        steady = 1'b0;
        repeat (SETTLE) @(negedge clk);

        $display("sent %0d positions, checked %0d cos/sin results", positions_sent,
                 results_checked);
        $display("layout writes: %0d, covering both paired and split element ordering",
                 layout_writes);
        if (fail_count == 0 && expected_pairs.size() == 0)
        begin
            $display("rotary_embedding_cos_sin_gen_unit: match");
        end
        else
        begin
            $display("rotary_embedding_cos_sin_gen_unit: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
